// ----- hw/rtl/gnb_pkg.sv -----
// Package for the grid neighbor binning engine: command and status codes, register addresses, FSM states.
// No dependencies.
package gnb_pkg;
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] REG_CELL_SIZE = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_CLR, S_INS_RD, S_INS_WR, S_Q_CELL, S_Q_CNT, S_Q_ENT, S_Q_DAT, S_OUT
	} state_t;
endpackage

// ----- hw/rtl/grid_neighbor_binning_top.sv -----
// Grid neighbor binning engine top level: divider, cell count and entry memories, sequencer.
// Depends on gnb_pkg.
//
//  channel | dir | handshake                 | payload
//  s_axis  | in  | s_tvalid/s_tready         | s_tuser: command; s_tdata: particle_index,
//          |     |                           |   pos_x, pos_y
//  m_axis  | out | m_tvalid/m_tready/m_tlast | m_tuser: neighbor_valid; m_tdata: status,
//          |     |                           |   neighbor_index
//  apb     | in  | psel/penable/pwrite/pready| cell_size, grid_width, grid_height
//
// One item at a time. Positions go through a 16-step restoring divider. Insert then needs
// a count read and, for an in-grid cell, a write step before its result is loaded. A query
// walks the nine neighbor cells, skips those outside the grid, reads the count of each
// in-grid one, then each found entry, and closes with a last result. Clear sweeps the
// count memory one cell a cycle. After reset the same sweep runs once; no item is taken
// until it ends. A result waits in the output register and holds the sequencer meanwhile.
module grid_neighbor_binning_top import gnb_pkg::*; #(
	parameter int MAX_GRID_SIDE = 32,
	parameter int CELL_CAP = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] command
	input  logic [1:0]  s_tuser,
	// [11:0] particle_index, [27:12] pos_x, [43:28] pos_y
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] neighbor_valid
	output logic        m_tuser,
	// [1:0] status, [13:2] neighbor_index
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int CW = (MAX_GRID_SIDE > 1) ? $clog2(MAX_GRID_SIDE) : 1;
	localparam int AW = 2 * CW;
	localparam int NCELL = 2 ** AW;
	localparam int NW = $clog2(CELL_CAP + 1);
	localparam int EW = $clog2(NCELL * CELL_CAP);
	localparam int KW = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;

	// configuration
	logic [15:0] cell_size_q;
	logic [5:0]  grid_width_q, grid_height_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q   <= 16'd256;
			grid_width_q  <= 6'd32;
			grid_height_q <= 6'd32;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_CELL_SIZE: cell_size_q   <= pwdata[15:0];
				REG_WIDTH:     grid_width_q  <= pwdata[5:0];
				REG_HEIGHT:    grid_height_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			REG_CELL_SIZE: prdata = {16'd0, cell_size_q};
			REG_WIDTH:     prdata = {26'd0, grid_width_q};
			REG_HEIGHT:    prdata = {26'd0, grid_height_q};
			default:       prdata = 32'd0;
		endcase
	end

	// effective grid sides, saturated
	logic [8:0] w_eff, h_eff;
	assign w_eff = ({3'b0, grid_width_q} > 9'(MAX_GRID_SIDE)) ? 9'(MAX_GRID_SIDE)
		: {3'b0, grid_width_q};
	assign h_eff = ({3'b0, grid_height_q} > 9'(MAX_GRID_SIDE)) ? 9'(MAX_GRID_SIDE)
		: {3'b0, grid_height_q};
	logic [15:0] divisor;
	assign divisor = (cell_size_q == 16'd0) ? 16'd1 : cell_size_q;

	// registers
	state_t state_q, state_d;
	logic [1:0]  cmd_q;
	logic [11:0] s_idx_q;
	logic [15:0] nx_q, ny_q;       // dividend/quotient shift registers
	logic [16:0] rx_q, ry_q;       // partial remainders
	logic [4:0]  step_q;
	logic [AW:0] clr_q;
	logic [3:0]  nb_q;             // neighbor number 0..8, 9 when all are done
	logic [KW-1:0] ent_q;
	logic [NW-1:0] n_q;
	logic        found_q;
	logic [11:0] ent_q_last_q;
	logic        out_v_q, out_last_q, out_nv_q;
	logic [1:0]  out_st_q;
	logic [11:0] out_idx_q;

	// memories
	logic [NW-1:0] cnt_mem [NCELL];
	logic [11:0]   ent_mem [NCELL*CELL_CAP];
	logic          cnt_we, ent_we;
	logic [AW-1:0] cnt_addr;
	logic [NW-1:0] cnt_wdata, cnt_rdata_q;
	logic [EW-1:0] ent_waddr, ent_raddr;
	logic [11:0]   ent_rdata_q;
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
		cnt_rdata_q <= cnt_mem[cnt_addr];
		if (ent_we) ent_mem[ent_waddr] <= s_idx_q;
		ent_rdata_q <= ent_mem[ent_raddr];
	end

	// neighbor offsets, dx outer and dy inner
	logic [1:0] ddx, ddy;
	always_comb begin
		case (nb_q) inside
			[4'd0:4'd2]: ddx = 2'd0;
			[4'd3:4'd5]: ddx = 2'd1;
			default:     ddx = 2'd2;
		endcase
		case (nb_q) inside
			4'd0, 4'd3, 4'd6: ddy = 2'd0;
			4'd1, 4'd4, 4'd7: ddy = 2'd1;
			default:          ddy = 2'd2;
		endcase
	end

	// current neighbor cell
	logic signed [17:0] ncx, ncy;
	logic nb_in;
	assign ncx = $signed({2'b0, nx_q}) + $signed({16'b0, ddx}) - 18'sd1;
	assign ncy = $signed({2'b0, ny_q}) + $signed({16'b0, ddy}) - 18'sd1;
	assign nb_in = !ncx[17] && !ncy[17] && (ncx < $signed({9'b0, w_eff}))
		&& (ncy < $signed({9'b0, h_eff}));
	logic [AW-1:0] ncell, icell;
	assign ncell = {ncy[CW-1:0], ncx[CW-1:0]};
	assign icell = {ny_q[CW-1:0], nx_q[CW-1:0]};
	logic ins_in;
	assign ins_in = ({1'b0, nx_q} < {8'b0, w_eff}) && ({1'b0, ny_q} < {8'b0, h_eff});

	// divider step
	logic [16:0] tx, ty;
	assign tx = {rx_q[15:0], nx_q[15]};
	assign ty = {ry_q[15:0], ny_q[15]};

	logic out_free;
	assign out_free = !out_v_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;

	// output register load
	logic out_load;
	assign out_load = out_free && ((state_q == S_OUT) || (state_q == S_Q_DAT && found_q)
		|| (state_q == S_Q_CELL && nb_q == 4'd9 && found_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (s_tvalid && s_tready) state_d = S_DIV;
			S_DIV:    if (step_q == 5'd15) begin
				case (cmd_q)
					CMD_CLEAR:  state_d = S_CLR;
					CMD_INSERT: state_d = S_INS_RD;
					CMD_QUERY:  state_d = S_Q_CELL;
					default:    state_d = S_OUT;
				endcase
			end
			S_CLR: begin
				// the sweep after reset returns idle with no result
				if (clr_q == (AW+1)'(NCELL - 1))
					state_d = (cmd_q == CMD_CLEAR) ? S_OUT : S_IDLE;
			end
			S_INS_RD: state_d = ins_in ? S_INS_WR : S_OUT;
			S_INS_WR: state_d = S_OUT;
			S_Q_CELL: begin
				if (nb_q == 4'd9) begin
					if (!found_q) state_d = S_OUT;
					else if (out_free) state_d = S_IDLE;
				end else if (nb_in) begin
					state_d = S_Q_CNT;
				end
			end
			S_Q_CNT:  state_d = (cnt_rdata_q == '0) ? S_Q_CELL : S_Q_ENT;
			S_Q_ENT:  state_d = S_Q_DAT;
			S_Q_DAT:  if (out_free) state_d = S_Q_ENT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
		if (state_q == S_Q_DAT && out_free && 32'(ent_q) + 1 >= 32'(n_q))
			state_d = S_Q_CELL;
	end

	// memory controls
	always_comb begin
		cnt_we = 1'b0;
		cnt_wdata = '0;
		cnt_addr = icell;
		ent_we = 1'b0;
		ent_waddr = EW'(32'(icell) * CELL_CAP + 32'(cnt_rdata_q));
		ent_raddr = EW'(32'(ncell) * CELL_CAP + 32'(ent_q));
		case (state_q)
			S_CLR: begin
				cnt_we = 1'b1;
				cnt_addr = clr_q[AW-1:0];
			end
			S_INS_WR: if (32'(cnt_rdata_q) < CELL_CAP) begin
				cnt_we = 1'b1;
				cnt_wdata = cnt_rdata_q + NW'(1);
				ent_we = 1'b1;
			end
			S_Q_CELL, S_Q_CNT, S_Q_ENT, S_Q_DAT: cnt_addr = ncell;
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cmd_q <= CMD_INSERT;
			clr_q <= '0;
			step_q <= '0;
			nb_q <= '0;
			ent_q <= '0;
			found_q <= 1'b0;
			out_v_q <= 1'b0;
			out_last_q <= 1'b0;
			out_nv_q <= 1'b0;
			out_st_q <= ST_OK;
			out_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					cmd_q <= s_tuser;
					s_idx_q <= s_tdata[11:0];
					nx_q <= s_tdata[27:12];
					ny_q <= s_tdata[43:28];
					rx_q <= '0;
					ry_q <= '0;
					step_q <= '0;
					clr_q <= '0;
					nb_q <= '0;
					found_q <= 1'b0;
					out_st_q <= ST_OK;
				end
				S_DIV: begin
					step_q <= step_q + 5'd1;
					if (tx >= {1'b0, divisor}) begin
						rx_q <= tx - {1'b0, divisor};
						nx_q <= {nx_q[14:0], 1'b1};
					end else begin
						rx_q <= tx;
						nx_q <= {nx_q[14:0], 1'b0};
					end
					if (ty >= {1'b0, divisor}) begin
						ry_q <= ty - {1'b0, divisor};
						ny_q <= {ny_q[14:0], 1'b1};
					end else begin
						ry_q <= ty;
						ny_q <= {ny_q[14:0], 1'b0};
					end
				end
				S_CLR: clr_q <= clr_q + 1'b1;
				S_INS_RD: if (!ins_in) out_st_q <= ST_RANGE;
				S_INS_WR: if (32'(cnt_rdata_q) >= CELL_CAP) out_st_q <= ST_FULL;
				S_Q_CELL: begin
					// skip cells outside the grid, hold on an in-grid one
					if (nb_q != 4'd9 && !nb_in) nb_q <= nb_q + 4'd1;
					if (nb_q == 4'd9 && found_q && out_free) begin
						out_last_q <= 1'b1;
						out_nv_q <= 1'b1;
						out_idx_q <= ent_q_last_q;
					end
				end
				S_Q_CNT: begin
					n_q <= cnt_rdata_q;
					ent_q <= '0;
					if (cnt_rdata_q == '0) nb_q <= nb_q + 4'd1;
				end
				S_Q_DAT: if (out_free) begin
					// hold one entry back so the final one can carry last
					if (found_q) begin
						out_last_q <= 1'b0;
						out_nv_q <= 1'b1;
						out_idx_q <= ent_q_last_q;
					end
					found_q <= 1'b1;
					ent_q_last_q <= ent_rdata_q;
					ent_q <= ent_q + KW'(1);
					if (32'(ent_q) + 1 >= 32'(n_q)) nb_q <= nb_q + 4'd1;
				end
				S_OUT: if (out_free) begin
					out_last_q <= 1'b1;
					out_nv_q <= 1'b0;
					out_idx_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_nv_q;
	assign m_tdata  = {2'b0, out_idx_q, out_st_q};
endmodule
